// ----- rtl/core/dive_sample_word_decoder_macros.svh -----
// Assertion macros for the dive sample word decoder.
// Used by the top level; depends on nothing else.
`ifndef DIVE_SAMPLE_WORD_DECODER_MACROS_SVH
`define DIVE_SAMPLE_WORD_DECODER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DSWD_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("dswd implication check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define DSWD_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("dswd next-cycle check failed");

`else

`define DSWD_ASSERT_IMP(lbl, ant, con)
`define DSWD_ASSERT_NEXT(lbl, ant, con)

`endif

`endif

// ----- rtl/core/dswd_pkg.sv -----
// Shared types and constants for the dive sample word decoder.
// No dependencies.
`default_nettype none

package dswd_pkg;

    // Record kinds as they appear on the output tuser.
    localparam logic [1:0] KIND_TIME  = 2'd0;
    localparam logic [1:0] KIND_DEPTH = 2'd1;
    localparam logic [1:0] KIND_TEMP  = 2'd2;
    localparam logic [1:0] KIND_GAS   = 2'd3;

    // Sample word types in bits 1..0.
    localparam logic [1:0] TYPE_SCUBA   = 2'd0;
    localparam logic [1:0] TYPE_FREE    = 2'd1;
    localparam logic [1:0] TYPE_SURFACE = 2'd2;
    localparam logic [1:0] TYPE_TEMP    = 2'd3;

    // Register indexes (byte address bits 3..2).
    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_MODE     = 2'd1;
    localparam logic [1:0] REG_VERSION  = 2'd2;

    localparam logic [2:0] MODE_SCUBA  = 3'd0;
    localparam logic [2:0] MODE_NITROX = 3'd1;

    // First format versions with the wide gas and wide free-depth fields.
    localparam logic [2:0] VER_WIDE_GAS   = 3'd3;
    localparam logic [2:0] VER_WIDE_DEPTH = 3'd4;

    localparam logic [12:0] INTERVAL_RESET = 13'd5000;
    localparam logic [23:0] MS_PER_S       = 24'd1000;

    localparam int MAX_RECORDS = 6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } rec_t;

    typedef struct packed {
        logic [2:0] count;
        rec_t [MAX_RECORDS-1:0] recs;
    } run_t;

    typedef struct packed {
        logic [31:0] elapsed_ms;
        logic [11:0] current_depth;
        logic [1:0]  current_gas;
        logic [1:0]  previous_gas;
        logic        previous_gas_valid;
        logic [13:0] pending_temperature;
        logic        temperature_waiting;
    } dive_state_t;

    typedef struct packed {
        logic [12:0] sample_interval_ms;
        logic [2:0]  dive_mode;
        logic [2:0]  format_version;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/dswd_run_builder.sv -----
// Combinational decode of one sample word into its run of records and the
// next dive state. Depends on dswd_pkg.
`default_nettype none

module dswd_run_builder
(
    input  wire logic [15:0]          sample_word,
    input  wire logic                 dive_start,
    input  wire dswd_pkg::cfg_t       cfg,
    input  wire dswd_pkg::dive_state_t state_cur,
    output dswd_pkg::dive_state_t     state_next,
    output dswd_pkg::run_t            run
);

    logic [1:0]            word_type;
    logic [13:0]           value;
    dswd_pkg::dive_state_t base;
    logic [23:0]           surf_ms;
    logic                  long_surface;
    logic [31:0]           time_interval;
    logic [31:0]           time_surface;
    logic                  gas_mode;

    assign word_type     = sample_word[1:0];
    assign value         = sample_word[15:2];
    assign base          = dive_start ? '0 : state_cur;
    assign surf_ms       = {10'd0, value} * dswd_pkg::MS_PER_S;
    assign long_surface  = surf_ms > {11'd0, cfg.sample_interval_ms};
    // The long-interval split adds interval, then surf - interval: the end
    // time is base + surf either way.
    assign time_interval = base.elapsed_ms + {19'd0, cfg.sample_interval_ms};
    assign time_surface  = base.elapsed_ms + {8'd0, surf_ms};
    assign gas_mode      = (cfg.dive_mode == dswd_pkg::MODE_SCUBA) ||
                           (cfg.dive_mode == dswd_pkg::MODE_NITROX);

    always_comb
    begin
        dswd_pkg::dive_state_t st;
        logic [2:0]            n;
        st = base;
        n  = 3'd0;
        run = '0;

        unique case (word_type)
            dswd_pkg::TYPE_SCUBA:
            begin
                st.current_depth = {1'b0, value[10:0]};
                if (cfg.format_version < dswd_pkg::VER_WIDE_GAS)
                    st.current_gas = {1'b0, value[11]};
                else
                    st.current_gas = value[12:11];
                st.elapsed_ms = time_interval;
            end
            dswd_pkg::TYPE_FREE:
            begin
                if (cfg.format_version < dswd_pkg::VER_WIDE_DEPTH)
                    st.current_depth = {1'b0, value[10:0]};
                else
                    st.current_depth = value[11:0];
                st.elapsed_ms = time_interval;
            end
            dswd_pkg::TYPE_SURFACE:
            begin
                if (long_surface)
                begin
                    run.recs[n] = '{kind: dswd_pkg::KIND_TIME, value: time_interval};
                    n = n + 3'd1;
                    run.recs[n] = '{kind: dswd_pkg::KIND_DEPTH, value: 32'd0};
                    n = n + 3'd1;
                end
                st.current_depth = 12'd0;
                st.elapsed_ms    = time_surface;
            end
            default:
            begin
                st.pending_temperature = value;
                st.temperature_waiting = 1'b1;
            end
        endcase

        if (word_type != dswd_pkg::TYPE_TEMP)
        begin
            run.recs[n] = '{kind: dswd_pkg::KIND_TIME, value: st.elapsed_ms};
            n = n + 3'd1;
            if (st.temperature_waiting)
            begin
                run.recs[n] = '{kind: dswd_pkg::KIND_TEMP,
                                value: {18'd0, st.pending_temperature}};
                n = n + 3'd1;
                st.temperature_waiting = 1'b0;
            end
            run.recs[n] = '{kind: dswd_pkg::KIND_DEPTH, value: {20'd0, st.current_depth}};
            n = n + 3'd1;
            if (gas_mode && (!st.previous_gas_valid || st.current_gas != st.previous_gas))
            begin
                run.recs[n] = '{kind: dswd_pkg::KIND_GAS, value: {30'd0, st.current_gas}};
                n = n + 3'd1;
                st.previous_gas       = st.current_gas;
                st.previous_gas_valid = 1'b1;
            end
        end

        run.count  = n;
        state_next = st;
    end

endmodule

`default_nettype wire

// ----- rtl/core/dive_sample_word_decoder.sv -----
// Top level of the dive sample word decoder: input register, state, record
// queue and configuration registers. Depends on dswd_pkg, dswd_run_builder
// and dive_sample_word_decoder_macros.svh.
//
// Usage. Sample words enter on the s_axis channel (tdata = sample word,
// tuser = dive start flag). Each depth or surface word yields a run of two
// to six records on the m_axis channel, one record per word there:
// tuser carries the record kind, tdata the 32-bit value, tlast marks the
// last record of the run. Temperature words only store their value and
// yield nothing. Software sets the sample interval, dive mode and format
// version through the APB port while the stream is idle.
// An accepted word waits in the input register until the queue is free,
// then is decoded in a single pass into the record queue, whose head is
// offered on m_axis. A run leaves one record per cycle while the receiver
// is ready; the next word is decoded in the cycle its predecessor's last
// record is taken, so runs follow back to back. Temperature words yield
// no records and, while the queue is empty, are decoded one per cycle.
// Reset clears the dive state, empties the queue and input register and
// loads the register reset values. When the receiver stalls, the current
// record holds, the input register fills, and s_axis_tready falls.
`default_nettype none

`include "dive_sample_word_decoder_macros.svh"

module dive_sample_word_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_word
    input  wire logic        s_axis_tuser,   // [0] dive_start

    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] record_value
    output logic [1:0]       m_axis_tuser,   // [1:0] record_kind
    output logic             m_axis_tlast,   // last_of_run

    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers.
    dswd_pkg::cfg_t cfg_reg;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval_ms <= dswd_pkg::INTERVAL_RESET;
            cfg_reg.dive_mode          <= dswd_pkg::MODE_SCUBA;
            cfg_reg.format_version     <= 3'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                dswd_pkg::REG_INTERVAL: cfg_reg.sample_interval_ms <= pwdata[12:0];
                dswd_pkg::REG_MODE:     cfg_reg.dive_mode          <= pwdata[2:0];
                dswd_pkg::REG_VERSION:  cfg_reg.format_version     <= pwdata[2:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dswd_pkg::REG_INTERVAL: prdata = {19'd0, cfg_reg.sample_interval_ms};
            dswd_pkg::REG_MODE:     prdata = {29'd0, cfg_reg.dive_mode};
            dswd_pkg::REG_VERSION:  prdata = {29'd0, cfg_reg.format_version};
            default:                prdata = 32'd0;
        endcase
    end

    // Input register: one word waiting to be decoded.
    logic        in_valid_reg;
    logic [15:0] in_word_reg;
    logic        in_start_reg;

    // Record queue: the run of the last decoded word, head in entry zero.
    logic [2:0]                             run_count_reg;
    dswd_pkg::rec_t [dswd_pkg::MAX_RECORDS-1:0] run_recs_reg;

    dswd_pkg::dive_state_t state_reg;
    dswd_pkg::dive_state_t state_next;
    dswd_pkg::run_t        run_next;

    logic out_take;
    logic queue_free;
    logic decode;
    logic in_take;

    assign out_take   = m_axis_tvalid && m_axis_tready;
    // The queue can take a new run once it is empty or its last record leaves now.
    assign queue_free = (run_count_reg == 3'd0) || (run_count_reg == 3'd1 && m_axis_tready);
    assign decode     = in_valid_reg && queue_free;
    assign s_axis_tready = !in_valid_reg || queue_free;
    assign in_take    = s_axis_tvalid && s_axis_tready;

    dswd_run_builder u_builder
    (
        .sample_word (in_word_reg),
        .dive_start  (in_start_reg),
        .cfg         (cfg_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .run         (run_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            run_count_reg <= 3'd0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (decode)
                in_valid_reg <= 1'b0;

            if (decode)
            begin
                state_reg     <= state_next;
                run_count_reg <= run_next.count;
            end
            else if (out_take)
                run_count_reg <= run_count_reg - 3'd1;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end

        if (decode)
            run_recs_reg <= run_next.recs;
        else if (out_take)
        begin
            for (int i = 0; i < dswd_pkg::MAX_RECORDS - 1; i++)
                run_recs_reg[i] <= run_recs_reg[i+1];
        end
    end

    assign m_axis_tvalid = run_count_reg != 3'd0;
    assign m_axis_tdata  = run_recs_reg[0].value;
    assign m_axis_tuser  = run_recs_reg[0].kind;
    assign m_axis_tlast  = run_count_reg == 3'd1;

    // A run never holds more records than one word can cause.
    `DSWD_ASSERT_IMP(a_count_bound, 1'b1, run_count_reg <= 3'd6)
    // A decoded depth or surface word leaves at least time and depth queued.
    `DSWD_ASSERT_NEXT(a_run_min, decode && in_word_reg[1:0] != dswd_pkg::TYPE_TEMP, run_count_reg >= 3'd2)
    // With more than one record left, a waiting word must not be replaced.
    `DSWD_ASSERT_IMP(a_hold_input, in_valid_reg && run_count_reg > 3'd1, !s_axis_tready)
    // Last record taken with nothing to decode leaves the output empty.
    `DSWD_ASSERT_NEXT(a_drain_empty, out_take && m_axis_tlast && !decode, !m_axis_tvalid)

endmodule

`default_nettype wire
